FILE: sv/amse_pkg.sv
// Shared types and constants for the MOV/MOVS shifter execute block.
`default_nettype none

package amse_pkg;

  // Data-processing opcode for MOV
  localparam logic [3:0] OpcMov = 4'd13;
  localparam logic [3:0] PcReg  = 4'd15;
  localparam logic [31:0] PcReadOffset = 32'd4;

  localparam logic [2:0] CyclesUnsup = 3'd1;
  localparam logic [2:0] CyclesImm   = 3'd2;
  localparam logic [2:0] CyclesReg   = 3'd3;
  localparam logic [2:0] CyclesPc    = 3'd2;

  localparam logic [7:0] ShiftFull = 8'd32;

  typedef enum logic [1:0] {
    KindImm,
    KindShImm,
    KindShReg,
    KindUnsup
  } kind_e;

  typedef enum logic [1:0] {
    ShLsl,
    ShLsr,
    ShAsr,
    ShRor
  } shift_e;

  // Decoded instruction handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic        set_flags;
    logic [3:0]  rd;
    logic [3:0]  rm;
    logic [3:0]  rs;
    shift_e      sh;
    logic [7:0]  amt;        // immediate shift amount, zero-amount cases normalized
    logic        rrx;
    logic [31:0] imm_val;    // rotated immediate
    logic        imm_rot_nz;
  } op_t;

endpackage

`default_nettype wire

FILE: sv/amse_front.sv
// Front end: accepts instruction words and decodes them into ops.
`default_nettype none

module amse_front
  import amse_pkg::*;
(
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] instruction
  input  wire logic        q_ready_i,
  output logic             push_o,
  output op_t              op_o
);

  logic [31:0] insn;
  logic [63:0] imm_rot;
  logic [4:0]  rot;

  assign insn = s_axis_tdata;
  assign s_axis_tready = q_ready_i;
  assign push_o = s_axis_tvalid && q_ready_i;

  always_comb begin
    rot = {insn[11:8], 1'b0};
    imm_rot = {24'd0, insn[7:0], 24'd0, insn[7:0]} >> rot;

    op_o.kind       = KindUnsup;
    op_o.set_flags  = insn[20];
    op_o.rd         = insn[15:12];
    op_o.rm         = insn[3:0];
    op_o.rs         = insn[11:8];
    op_o.sh         = shift_e'(insn[6:5]);
    op_o.amt        = {3'd0, insn[11:7]};
    op_o.rrx        = 1'b0;
    op_o.imm_val    = imm_rot[31:0];
    op_o.imm_rot_nz = insn[11:8] != 4'd0;

    if (insn[27:26] == 2'b00 && insn[24:21] == OpcMov) begin
      priority if (insn[25]) begin
        op_o.kind = KindImm;
      end else if (!insn[4]) begin
        op_o.kind = KindShImm;
        // zero amount: LSR/ASR mean 32, ROR means RRX
        if (insn[11:7] == 5'd0) begin
          unique case (shift_e'(insn[6:5]))
            ShLsl: op_o.amt = 8'd0;
            ShLsr,
            ShAsr: op_o.amt = ShiftFull;
            ShRor: op_o.rrx = 1'b1;
            default: op_o.amt = 8'd0;
          endcase
        end
      end else if (!insn[7]) begin
        op_o.kind = KindShReg;
      end else begin
        op_o.kind = KindUnsup;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/amse_queue.sv
// Small FIFO of decoded ops between front and back.
`default_nettype none

module amse_queue
  import amse_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       op_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/amse_back.sv
// Back end: register file read, barrel shifter, writeback, flags and result word.
`default_nettype none

module amse_back
  import amse_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  wire op_t   q_op_i,
  output logic       q_pop_o,
  output logic       m_axis_tvalid,
  input  wire logic  m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [3:0] dest_reg, [35:4] result_value,
                                     // [36] neg_flag, [37] zero_flag, [38] carry_flag,
                                     // [39] pc_written, [42:40] cycle_count, rest zero
  output logic       m_axis_tuser    // [0] status
);

  // register file with per-entry valid bits (unwritten reads as zero)
  logic [31:0] rf_q [16];
  logic [15:0] rf_vld_q;

  logic flag_n_q, flag_z_q, flag_c_q;

  // execute stage
  logic        a_valid_q;
  op_t         a_op_q;
  logic [31:0] rm_data_q, rs_data_q, fwd_data_q;
  logic        rm_vld_q, rs_vld_q, rm_fwd_q, rs_fwd_q;

  // output register
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_status_q;

  logic        out_ready, advance, commit;
  logic [31:0] rm_val, rs_val, op2;
  logic        carry, supported;
  logic        n_next, z_next, c_next;
  logic [7:0]  amt;
  logic [32:0] lsl_t, lsr_t;
  logic signed [32:0] asr_t;
  logic [63:0] ror_t;
  logic [2:0]  cycles;
  logic        pc_wr;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign advance   = a_valid_q && out_ready;
  assign supported = a_op_q.kind != KindUnsup;
  assign commit    = advance && supported;
  assign q_pop_o   = q_valid_i && (!a_valid_q || out_ready);

  // operand fetch with bypass of the word committed alongside the read
  always_comb begin
    rm_val = rm_fwd_q ? fwd_data_q : (rm_vld_q ? rm_data_q : 32'd0);
    rs_val = rs_fwd_q ? fwd_data_q : (rs_vld_q ? rs_data_q : 32'd0);
    if (a_op_q.rm == PcReg) rm_val = rm_val + PcReadOffset;
    if (a_op_q.rs == PcReg) rs_val = rs_val + PcReadOffset;
  end

  // barrel shifter
  always_comb begin
    amt   = (a_op_q.kind == KindShReg) ? rs_val[7:0] : a_op_q.amt;
    lsl_t = {1'b0, rm_val} << amt[4:0];
    lsr_t = {rm_val, 1'b0} >> amt[4:0];
    asr_t = $signed({rm_val, 1'b0}) >>> amt[4:0];
    ror_t = {rm_val, rm_val} >> amt[4:0];
    op2   = rm_val;
    carry = flag_c_q;
    priority if (a_op_q.kind == KindImm) begin
      op2   = a_op_q.imm_val;
      carry = a_op_q.imm_rot_nz ? a_op_q.imm_val[31] : flag_c_q;
    end else if (a_op_q.kind == KindUnsup) begin
      op2   = 32'd0;
      carry = flag_c_q;
    end else if (a_op_q.rrx && a_op_q.kind == KindShImm) begin
      op2   = {flag_c_q, rm_val[31:1]};
      carry = rm_val[0];
    end else if (amt == 8'd0) begin
      op2   = rm_val;
      carry = flag_c_q;
    end else begin
      unique case (a_op_q.sh)
        ShLsl: begin
          if (amt < ShiftFull) begin
            op2   = lsl_t[31:0];
            carry = lsl_t[32];
          end else begin
            op2   = 32'd0;
            carry = (amt == ShiftFull) ? rm_val[0] : 1'b0;
          end
        end
        ShLsr: begin
          if (amt < ShiftFull) begin
            op2   = lsr_t[32:1];
            carry = lsr_t[0];
          end else begin
            op2   = 32'd0;
            carry = (amt == ShiftFull) ? rm_val[31] : 1'b0;
          end
        end
        ShAsr: begin
          if (amt < ShiftFull) begin
            op2   = asr_t[32:1];
            carry = asr_t[0];
          end else begin
            op2   = {32{rm_val[31]}};
            carry = rm_val[31];
          end
        end
        ShRor: begin
          op2   = ror_t[31:0];
          carry = ror_t[31];
        end
        default: begin
          op2   = rm_val;
          carry = flag_c_q;
        end
      endcase
    end
  end

  always_comb begin
    n_next = flag_n_q;
    z_next = flag_z_q;
    c_next = flag_c_q;
    if (supported && a_op_q.set_flags) begin
      n_next = op2[31];
      z_next = op2 == 32'd0;
      c_next = carry;
    end
    pc_wr  = supported && a_op_q.rd == PcReg;
    cycles = (a_op_q.kind == KindShReg) ? CyclesReg : CyclesImm;
    if (pc_wr) cycles = cycles + CyclesPc;
    if (!supported) cycles = CyclesUnsup;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q    <= '0;
      flag_n_q    <= 1'b0;
      flag_z_q    <= 1'b0;
      flag_c_q    <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        rf_vld_q[a_op_q.rd] <= 1'b1;
        flag_n_q <= n_next;
        flag_z_q <= z_next;
        flag_c_q <= c_next;
      end
      if (q_pop_o) begin
        a_valid_q <= 1'b1;
      end else if (out_ready) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rf_q[a_op_q.rd] <= op2;
    end
    if (q_pop_o) begin
      a_op_q     <= q_op_i;
      rm_data_q  <= rf_q[q_op_i.rm];
      rs_data_q  <= rf_q[q_op_i.rs];
      rm_vld_q   <= rf_vld_q[q_op_i.rm];
      rs_vld_q   <= rf_vld_q[q_op_i.rs];
      rm_fwd_q   <= commit && a_op_q.rd == q_op_i.rm;
      rs_fwd_q   <= commit && a_op_q.rd == q_op_i.rs;
      fwd_data_q <= op2;
    end
    if (advance) begin
      out_status_q <= !supported;
      out_data_q   <= {5'd0, cycles, pc_wr, c_next, z_next, n_next,
                       supported ? op2 : 32'd0,
                       supported ? a_op_q.rd : 4'd0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

FILE: sv/arm_mov_shifter_execute.sv
// Top level: ARM MOV/MOVS execute with barrel-shifter operand 2.
//
//  channel  dir  word contents
//  s_axis   in   tdata[31:0] instruction
//  m_axis   out  tuser status; tdata dest_reg, result_value, N, Z, C, pc_written,
//                cycle_count
//
// Sustains one instruction per clock while m_axis is ready; a word that is taken
// passes the queue, the register read and execute into the output register on its way to m_axis.
// The register-file read/bypass and the single execute stage lie on that path.
// Reset clears registers r0-r15 (valid bits) and the flags at once.
// Either side may stall; the queue absorbs up to QueueDepth decoded words.
`default_nettype none

module arm_mov_shifter_execute
  import amse_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] instruction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [3:0] dest_reg, [35:4] result_value,
                                           // [36] neg_flag, [37] zero_flag,
                                           // [38] carry_flag, [39] pc_written,
                                           // [42:40] cycle_count, [47:43] zero
  output logic             m_axis_tuser    // [0] status
);

  logic q_ready, push, q_valid, pop;
  op_t  push_op, head_op;

  amse_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .op_o          (push_op)
  );

  amse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  amse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_op_i        (head_op),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/arm_mov_shifter_execute_tb.sv
// Testbench for arm_mov_shifter_execute: random and directed MOV/MOVS words vs a predictor.
`timescale 1ns / 1ps

module arm_mov_shifter_execute_tb
  import amse_pkg::*;
;

  localparam int unsigned RandomWords = 1500;
  localparam int unsigned HoldAt      = 500;     // results seen before the long hold-off
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 300000;

  typedef struct packed {
    logic        status;
    logic [3:0]  dest;
    logic [31:0] value;
    logic        n;
    logic        z;
    logic        c;
    logic        pc;
    logic [2:0]  cycles;
  } writeback_t;

  typedef enum int {
    BreakRegBit7,
    BreakOpcode,
    BreakClass
  } break_e;

  // Architectural state of the emulated core plus the writebacks still owed.
  class mov_exec_tracker;
    logic [31:0] regs [16];
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    writeback_t  owed[$];
    int unsigned fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      flag_n = 1'b0;
      flag_z = 1'b0;
      flag_c = 1'b0;
      fails  = 0;
    endfunction

    function logic [31:0] read_operand(logic [3:0] idx);
      return (idx == PcReg) ? regs[idx] + PcReadOffset : regs[idx];
    endfunction

    function logic [31:0] ror32(logic [31:0] v, int unsigned n);
      n = n % 32;
      if (n == 0) return v;
      return (v >> n) | (v << (32 - n));
    endfunction

    // n is 1..255; carry is updated in place
    function logic [31:0] barrel(shift_e sh, logic [31:0] v, int unsigned n, inout logic c);
      int unsigned r;
      case (sh)
        ShLsl: begin
          if (n < 32) begin
            c = v[32 - n];
            return v << n;
          end
          c = (n == 32) ? v[0] : 1'b0;
          return '0;
        end
        ShLsr: begin
          if (n < 32) begin
            c = v[n - 1];
            return v >> n;
          end
          c = (n == 32) ? v[31] : 1'b0;
          return '0;
        end
        ShAsr: begin
          if (n < 32) begin
            c = v[n - 1];
            return $unsigned($signed(v) >>> n);
          end
          c = v[31];
          return {32{v[31]}};
        end
        default: begin
          r = n % 32;
          if (r == 0) begin
            c = v[31];
            return v;
          end
          c = v[r - 1];
          return ror32(v, r);
        end
      endcase
    endfunction

    function void note_instruction(logic [31:0] insn);
      writeback_t  res;
      logic [31:0] op2;
      logic [31:0] v;
      logic [31:0] rs_val;
      logic        c;
      logic        ok;
      logic [3:0]  rd;
      logic [2:0]  cyc;
      shift_e      sh;
      int unsigned amt;
      c   = flag_c;
      ok  = 1'b0;
      op2 = '0;
      cyc = CyclesImm;
      rd  = insn[15:12];
      sh  = shift_e'(insn[6:5]);
      if (insn[27:26] == 2'b00 && insn[24:21] == OpcMov) begin
        if (insn[25]) begin
          amt = 2 * insn[11:8];
          op2 = ror32({24'b0, insn[7:0]}, amt);
          if (amt != 0) c = op2[31];
          ok = 1'b1;
        end else if (!insn[4]) begin
          amt = insn[11:7];
          v   = read_operand(insn[3:0]);
          if (amt != 0) op2 = barrel(sh, v, amt, c);
          else if (sh == ShLsl) op2 = v;
          else if (sh == ShRor) begin
            // RRX
            c   = v[0];
            op2 = {flag_c, v[31:1]};
          end else op2 = barrel(sh, v, ShiftFull, c);
          ok = 1'b1;
        end else if (!insn[7]) begin
          rs_val = read_operand(insn[11:8]);
          amt    = rs_val[7:0];
          v      = read_operand(insn[3:0]);
          if (amt != 0) op2 = barrel(sh, v, amt, c);
          else op2 = v;
          cyc = CyclesReg;
          ok  = 1'b1;
        end
      end
      if (!ok) begin
        res.status = 1'b1;
        res.dest   = '0;
        res.value  = '0;
        res.pc     = 1'b0;
        res.cycles = CyclesUnsup;
      end else begin
        regs[rd] = op2;
        if (rd == PcReg) cyc += CyclesPc;
        if (insn[20]) begin
          flag_n = op2[31];
          flag_z = (op2 == 0);
          flag_c = c;
        end
        res.status = 1'b0;
        res.dest   = rd;
        res.value  = op2;
        res.pc     = (rd == PcReg);
        res.cycles = cyc;
      end
      res.n = flag_n;
      res.z = flag_z;
      res.c = flag_c;
      owed.push_back(res);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        fails++;
      end
    endfunction

    function void check_writeback(logic status, logic [47:0] data);
      writeback_t want;
      if (owed.size() == 0) begin
        $error("result word with nothing owed: tuser %b tdata %h", status, data);
        fails++;
        return;
      end
      want = owed.pop_front();
      compare("status", want.status, status);
      compare("dest_reg", want.dest, data[3:0]);
      compare("result_value", want.value, data[35:4]);
      compare("neg_flag", want.n, data[36]);
      compare("zero_flag", want.z, data[37]);
      compare("carry_flag", want.c, data[38]);
      compare("pc_written", want.pc, data[39]);
      compare("cycle_count", want.cycles, data[42:40]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  mov_exec_tracker tracker = new();

  int unsigned burst_left = 1;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cyc = 0;
  int unsigned cyc_count = 0;
  bit          held = 1'b0;

  arm_mov_shifter_execute u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check accepted words, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_writeback(m_axis_tuser, m_axis_tdata);
        results_seen++;
      end
      rx_cyc++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && results_seen >= HoldAt) begin
        held = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cyc[9:8])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2'd2: m_axis_tready <= ($urandom_range(0, 4) != 0);
          default: m_axis_tready <= (rx_cyc[2:0] != 3'd0);
        endcase
      end
    end
  end

  function automatic logic [31:0] enc_imm(logic s, logic [3:0] rd, logic [3:0] rot,
                                          logic [7:0] imm8);
    return {4'($urandom), 2'b00, 1'b1, OpcMov, s, 4'($urandom), rd, rot, imm8};
  endfunction

  function automatic logic [31:0] enc_shimm(logic s, logic [3:0] rd, logic [3:0] rm,
                                            logic [4:0] amt, shift_e sh);
    return {4'($urandom), 2'b00, 1'b0, OpcMov, s, 4'($urandom), rd, amt, sh, 1'b0, rm};
  endfunction

  function automatic logic [31:0] enc_shreg(logic s, logic [3:0] rd, logic [3:0] rm,
                                            logic [3:0] rs, shift_e sh);
    return {4'($urandom), 2'b00, 1'b0, OpcMov, s, 4'($urandom), rd, rs, 1'b0, sh, 1'b1, rm};
  endfunction

  function automatic logic [31:0] mangle(logic [31:0] w, break_e how);
    logic [3:0] opc;
    case (how)
      BreakRegBit7: w[7] = 1'b1;
      BreakOpcode: begin
        do opc = 4'($urandom); while (opc == OpcMov);
        w[24:21] = opc;
      end
      default: w[27:26] = 2'($urandom_range(1, 3));
    endcase
    return w;
  endfunction

  // shift amounts worth loading into a register
  function automatic logic [7:0] pick_amount();
    case ($urandom_range(0, 10))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd31;
      3: return 8'd32;
      4: return 8'd33;
      5: return 8'd63;
      6: return 8'd64;
      7: return 8'd96;
      8: return 8'd128;
      9: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_instruction(w);
  endtask

  task automatic offer(input logic [31:0] w);
    int unsigned gap;
    send_word(w);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.owed.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)
      return enc_imm(1'($urandom), 4'($urandom),
                     ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom), pick_amount());
    if (pick < 45)
      return enc_shimm(1'($urandom), 4'($urandom), 4'($urandom),
                       ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom),
                       shift_e'($urandom_range(0, 3)));
    if (pick < 75)
      return enc_shreg(1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                       shift_e'($urandom_range(0, 3)));
    if (pick < 88)
      return $urandom;
    return mangle(enc_shreg(1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                            shift_e'($urandom_range(0, 3))),
                  break_e'($urandom_range(0, 2)));
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(enc_imm(1'b1, 4'd0, 4'd0, 8'h00));     // zero result, rotate 0 keeps C
    offer(enc_imm(1'b1, 4'd1, 4'd4, 8'hFF));     // rotated immediate sets C
    offer(enc_imm(1'b0, 4'd2, 4'd1, 8'h06));     // r2 = 0x80000001, flags kept
    offer(enc_shimm(1'b1, 4'd3, 4'd2, 5'd0, ShLsl));
    offer(enc_shimm(1'b1, 4'd4, 4'd2, 5'd0, ShLsr));
    offer(enc_shimm(1'b1, 4'd5, 4'd2, 5'd0, ShAsr));
    offer(enc_shimm(1'b1, 4'd6, 4'd2, 5'd0, ShRor)); // RRX
    offer(enc_shimm(1'b1, 4'd7, 4'd2, 5'd31, ShLsl));
    offer(enc_shimm(1'b1, 4'd7, 4'd2, 5'd1, ShRor));
    offer(enc_imm(1'b0, 4'd8, 4'd0, 8'd32));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShLsl));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShLsr));
    offer(enc_imm(1'b0, 4'd8, 4'd0, 8'd33));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShLsl));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShAsr));
    offer(enc_imm(1'b0, 4'd8, 4'd0, 8'd64));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShRor));
    offer(enc_imm(1'b0, 4'd8, 4'd0, 8'd0));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShLsl));
    offer(enc_imm(1'b0, 4'd8, 4'd0, 8'hFF));
    offer(enc_shreg(1'b1, 4'd9, 4'd2, 4'd8, ShRor));
    offer(enc_shimm(1'b1, 4'd10, PcReg, 5'd1, ShLsl)); // r15 read sees +4
    offer(enc_imm(1'b1, PcReg, 4'd0, 8'h04));          // write to r15
    offer(enc_shreg(1'b0, 4'd11, 4'd2, PcReg, ShLsr));
    offer(mangle(enc_shreg(1'b1, 4'd12, 4'd2, 4'd8, ShLsl), BreakRegBit7));
    offer(mangle(enc_imm(1'b1, 4'd12, 4'd0, 8'h01), BreakOpcode));
    offer(mangle(enc_shimm(1'b1, 4'd12, 4'd2, 5'd3, ShAsr), BreakClass));
    drain();

    for (int unsigned i = 0; i < RandomWords; i++) begin
      if (i == RandomWords / 2) drain();
      offer(random_word());
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
